// File: design/pixel_to_hex_axial_pick_macros.svh
// Assertion macros shared by the hex pick checker.
`ifndef PIXEL_TO_HEX_AXIAL_PICK_MACROS_SVH
`define PIXEL_TO_HEX_AXIAL_PICK_MACROS_SVH

// Antecedent implies consequent, sampled on the clock, off during reset.
`define HXP_ASSERT_IMPL(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hex pick check failed");

// Expression holds on every clock outside reset.
`define HXP_ASSERT_ALWAYS(label, clock, rstn, expr) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) (expr)) \
        else $error("hex pick check failed");

`endif

// File: design/hxp_pkg.sv
// Types and constants of the flat-top hex tile pick.
package hxp_pkg;

    localparam int PIX_W      = 11;
    localparam int CTR_W      = 13;
    localparam int COEF_W     = 18;
    localparam int DIFF_W     = 14;
    localparam int PROD_W     = 33;
    localparam int ACC_W      = 36;
    localparam int QR_W       = 11;
    localparam int S_W        = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int LANES      = 3;
    localparam int PIPE_DEPTH = 7;

    // Lane order of the three cube coordinates
    localparam int LANE_Q = 0;
    localparam int LANE_R = 1;
    localparam int LANE_S = 2;

    // Output ranges
    localparam int QR_MIN = -1024;
    localparam int QR_MAX = 1023;
    localparam int S_MAX  = 2047;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Q_COEF_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R_COEF_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_R_COEF_Y = 3'd4;

    // Reset values
    localparam logic [CTR_W-1:0]  RST_CENTER_X = 13'd600;
    localparam logic [CTR_W-1:0]  RST_CENTER_Y = 13'd390;
    localparam logic [COEF_W-1:0] RST_Q_COEF_X = 18'd1214;
    localparam logic [COEF_W-1:0] RST_R_COEF_X = 18'd607;
    localparam logic [COEF_W-1:0] RST_R_COEF_Y = 18'd2102;

    typedef struct packed {
        logic [CTR_W-1:0]  center_x_half;
        logic [CTR_W-1:0]  center_y_half;
        logic [COEF_W-1:0] q_coef_x;
        logic [COEF_W-1:0] r_coef_x;
        logic [COEF_W-1:0] r_coef_y;
    } hxp_cfg_t;

endpackage

// File: design/hxp_cfg.sv
// Configuration register bank of the hex tile pick.
module hxp_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hxp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hxp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output hxp_pkg::hxp_cfg_t                 cfg
);

    hxp_pkg::hxp_cfg_t cfg_reg;
    hxp_pkg::hxp_cfg_t cfg_next;

    // Decode the write; an unknown index leaves every register as it is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                hxp_pkg::REG_CENTER_X:
                    cfg_next.center_x_half = cfg_data[hxp_pkg::CTR_W-1:0];
                hxp_pkg::REG_CENTER_Y:
                    cfg_next.center_y_half = cfg_data[hxp_pkg::CTR_W-1:0];
                hxp_pkg::REG_Q_COEF_X:
                    cfg_next.q_coef_x = cfg_data[hxp_pkg::COEF_W-1:0];
                hxp_pkg::REG_R_COEF_X:
                    cfg_next.r_coef_x = cfg_data[hxp_pkg::COEF_W-1:0];
                hxp_pkg::REG_R_COEF_Y:
                    cfg_next.r_coef_y = cfg_data[hxp_pkg::COEF_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x_half <= hxp_pkg::RST_CENTER_X;
            cfg_reg.center_y_half <= hxp_pkg::RST_CENTER_Y;
            cfg_reg.q_coef_x      <= hxp_pkg::RST_Q_COEF_X;
            cfg_reg.r_coef_x      <= hxp_pkg::RST_R_COEF_X;
            cfg_reg.r_coef_y      <= hxp_pkg::RST_R_COEF_Y;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/hxp_map.sv
// Offset, coefficient multiply and sum stages: pixel to scaled q, r, s.
module hxp_map
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  hxp_pkg::hxp_cfg_t                      cfg,
    input  logic                                   in_valid,
    input  logic [hxp_pkg::PIX_W-1:0]              pixel_x,
    input  logic [hxp_pkg::PIX_W-1:0]              pixel_y,
    output logic                                   out_valid,
    output logic signed [hxp_pkg::ACC_W-1:0]       acc [hxp_pkg::LANES]
);

    localparam int DW = hxp_pkg::DIFF_W;
    localparam int PW = hxp_pkg::PROD_W;
    localparam int AW = hxp_pkg::ACC_W;

    logic                 va_reg, vb_reg, vc_reg;
    logic signed [DW-1:0] dxh_reg, dyh_reg;
    logic signed [DW-1:0] dxh_next, dyh_next;
    logic signed [PW-1:0] pq_reg, px_reg, py_reg;
    logic signed [PW-1:0] pq_next, px_next, py_next;
    logic signed [AW-1:0] qa_reg, ra_reg, sa_reg;
    logic signed [AW-1:0] qa_next, ra_next, sa_next;

    // Offset from the centre in half pixels
    always_comb
    begin
        dxh_next = $signed({2'b00, pixel_x, 1'b0}) - $signed({1'b0, cfg.center_x_half});
        dyh_next = $signed({2'b00, pixel_y, 1'b0}) - $signed({1'b0, cfg.center_y_half});
    end

    // Scale by the three coefficients
    always_comb
    begin
        pq_next = $signed({1'b0, cfg.q_coef_x}) * dxh_reg;
        px_next = $signed({1'b0, cfg.r_coef_x}) * dxh_reg;
        py_next = $signed({1'b0, cfg.r_coef_y}) * dyh_reg;
    end

    // Form q, r and s at full precision
    always_comb
    begin
        qa_next = AW'(pq_reg);
        ra_next = AW'(py_reg) - AW'(px_reg);
        sa_next = AW'(px_reg) - AW'(py_reg) - AW'(pq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dxh_reg <= dxh_next;
        dyh_reg <= dyh_next;
        pq_reg  <= pq_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
        qa_reg  <= qa_next;
        ra_reg  <= ra_next;
        sa_reg  <= sa_next;
    end

    assign out_valid                = vc_reg;
    assign acc[hxp_pkg::LANE_Q]     = qa_reg;
    assign acc[hxp_pkg::LANE_R]     = ra_reg;
    assign acc[hxp_pkg::LANE_S]     = sa_reg;

endmodule

// File: design/hxp_round.sv
// Round half away from zero and rounding error, one lane per coordinate.
module hxp_round
#(
    parameter int SCALE_W = 17
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [hxp_pkg::ACC_W-1:0]       acc [hxp_pkg::LANES],
    output logic                                   out_valid,
    output logic        [hxp_pkg::ACC_W-SCALE_W:0] mag [hxp_pkg::LANES],
    output logic                                   neg [hxp_pkg::LANES],
    output logic        [SCALE_W-1:0]              err [hxp_pkg::LANES]
);

    localparam int AW  = hxp_pkg::ACC_W;
    localparam int N_W = AW - SCALE_W + 1;
    localparam logic [AW:0] HALF = (AW + 1)'(1) << (SCALE_W - 1);

    logic vd_reg, ve_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            vd_reg <= in_valid;
            ve_reg <= vd_reg;
        end
    end

    for (genvar i = 0; i < hxp_pkg::LANES; i++)
    begin : g_lane
        logic [AW-1:0]      acc_u;
        logic [AW-1:0]      abs_reg, abs_next;
        logic               neg_reg, neg2_reg;
        logic [AW:0]        sum;
        logic [SCALE_W-1:0] frac;
        logic [N_W-1:0]     n_reg, n_next;
        logic [SCALE_W-1:0] err_reg, err_next;

        // Split into sign and magnitude
        always_comb
        begin
            acc_u    = acc[i];
            abs_next = acc[i][AW-1] ? (~acc_u + 1'b1) : acc_u;
        end

        // Add half and drop the fraction; error is distance to the nearest step
        always_comb
        begin
            sum      = {1'b0, abs_reg} + HALF;
            n_next   = sum[AW:SCALE_W];
            frac     = abs_reg[SCALE_W-1:0];
            err_next = frac[SCALE_W-1] ? (~frac + 1'b1) : frac;
        end

        always_ff @(posedge clk)
        begin
            abs_reg  <= abs_next;
            neg_reg  <= acc[i][AW-1];
            n_reg    <= n_next;
            err_reg  <= err_next;
            neg2_reg <= neg_reg;
        end

        assign mag[i] = n_reg;
        assign neg[i] = neg2_reg;
        assign err[i] = err_reg;
    end

    assign out_valid = ve_reg;

endmodule

// File: design/hxp_pick.sv
// Rebuild the worst-rounded coordinate and saturate to the output ranges.
module hxp_pick
#(
    parameter int SCALE_W = 17
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic        [hxp_pkg::ACC_W-SCALE_W:0] mag [hxp_pkg::LANES],
    input  logic                                   neg [hxp_pkg::LANES],
    input  logic        [SCALE_W-1:0]              err [hxp_pkg::LANES],
    output logic                                   out_valid,
    output logic signed [hxp_pkg::QR_W-1:0]        hex_q,
    output logic signed [hxp_pkg::QR_W-1:0]        hex_r,
    output logic signed [hxp_pkg::S_W-1:0]         hex_s
);

    localparam int N_W   = hxp_pkg::ACC_W - SCALE_W + 1;
    localparam int R_W   = N_W + 1;
    localparam int REB_W = R_W + 1;
    localparam int QW    = hxp_pkg::QR_W;
    localparam int SW    = hxp_pkg::S_W;
    localparam logic signed [REB_W-1:0] LO = REB_W'(hxp_pkg::QR_MIN);
    localparam logic signed [REB_W-1:0] HI = REB_W'(hxp_pkg::QR_MAX);
    localparam logic signed [SW:0]      SHI = (SW + 1)'(hxp_pkg::S_MAX);

    logic                    vf_reg, vg_reg;
    logic signed [R_W-1:0]   val [hxp_pkg::LANES];
    logic signed [REB_W-1:0] q_sel_reg, r_sel_reg, q_sel_next, r_sel_next;
    logic signed [REB_W-1:0] q_alt, r_alt;
    logic signed [QW-1:0]    q_clamp, r_clamp;
    logic signed [SW:0]      s_full;
    logic signed [SW-1:0]    s_next;
    logic signed [QW-1:0]    q_out_reg, r_out_reg;
    logic signed [SW-1:0]    s_out_reg;

    // Apply the signs
    for (genvar i = 0; i < hxp_pkg::LANES; i++)
    begin : g_sign
        assign val[i] = neg[i] ? -$signed({1'b0, mag[i]}) : $signed({1'b0, mag[i]});
    end

    // Rebuild the coordinate with the largest error; ties fall to the later one
    always_comb
    begin
        q_alt = -REB_W'(val[hxp_pkg::LANE_R]) - REB_W'(val[hxp_pkg::LANE_S]);
        r_alt = -REB_W'(val[hxp_pkg::LANE_Q]) - REB_W'(val[hxp_pkg::LANE_S]);
        q_sel_next = REB_W'(val[hxp_pkg::LANE_Q]);
        r_sel_next = REB_W'(val[hxp_pkg::LANE_R]);
        if ((err[hxp_pkg::LANE_Q] > err[hxp_pkg::LANE_R]) &&
            (err[hxp_pkg::LANE_Q] > err[hxp_pkg::LANE_S]))
        begin
            q_sel_next = q_alt;
        end
        else if (err[hxp_pkg::LANE_R] > err[hxp_pkg::LANE_S])
        begin
            r_sel_next = r_alt;
        end
    end

    // Saturate q and r, then derive s from the clamped pair
    always_comb
    begin
        if (q_sel_reg < LO)
            q_clamp = QW'(LO);
        else if (q_sel_reg > HI)
            q_clamp = QW'(HI);
        else
            q_clamp = QW'(q_sel_reg);

        if (r_sel_reg < LO)
            r_clamp = QW'(LO);
        else if (r_sel_reg > HI)
            r_clamp = QW'(HI);
        else
            r_clamp = QW'(r_sel_reg);

        s_full = -((SW + 1)'(q_clamp) + (SW + 1)'(r_clamp));
        s_next = (s_full > SHI) ? SW'(SHI) : SW'(s_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end
        else
        begin
            vf_reg <= in_valid;
            vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q_sel_reg <= q_sel_next;
        r_sel_reg <= r_sel_next;
        q_out_reg <= q_clamp;
        r_out_reg <= r_clamp;
        s_out_reg <= s_next;
    end

    assign out_valid = vg_reg;
    assign hex_q     = q_out_reg;
    assign hex_r     = r_out_reg;
    assign hex_s     = s_out_reg;

endmodule

// File: design/pixel_to_hex_axial_pick.sv
// Top level of the flat-top hex tile pick: pixel in, axial/cube tile out.
//
//  channel   direction  handshake             payload
//  pick      in         start (busy low)      pixel_x, pixel_y
//  tile      out        done, one cycle       hex_q, hex_r, hex_s
//  config    in         cfg_we                cfg_index, cfg_data
//
//  A transaction is taken every cycle; busy stays low.
//  The result passes through offset, multiply, sum, magnitude, round,
//  rebuild and saturate, each of which takes one register stage.
//  Reset clears the stage valid bits and loads the register defaults.
//  The receiver cannot stall, so there is no back pressure.
module pixel_to_hex_axial_pick
#(
    parameter int COEF_FRAC_BITS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [hxp_pkg::PIX_W-1:0]             pixel_x,
    input  logic [hxp_pkg::PIX_W-1:0]             pixel_y,
    output logic                                  done,
    output logic signed [hxp_pkg::QR_W-1:0]       hex_q,
    output logic signed [hxp_pkg::QR_W-1:0]       hex_r,
    output logic signed [hxp_pkg::S_W-1:0]        hex_s,
    input  logic                                  cfg_we,
    input  logic [hxp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hxp_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int SCALE_W = COEF_FRAC_BITS + 1;
    localparam int N_W     = hxp_pkg::ACC_W - SCALE_W + 1;

    hxp_pkg::hxp_cfg_t cfg;
    logic                              map_valid, rnd_valid;
    logic signed [hxp_pkg::ACC_W-1:0]  acc [hxp_pkg::LANES];
    logic        [N_W-1:0]             mag [hxp_pkg::LANES];
    logic                              neg [hxp_pkg::LANES];
    logic        [SCALE_W-1:0]         err [hxp_pkg::LANES];

    // Pipeline never holds off a transaction
    assign busy = 1'b0;

    hxp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hxp_map u_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (start & ~busy),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .out_valid (map_valid),
        .acc       (acc)
    );

    hxp_round #(.SCALE_W(SCALE_W)) u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (map_valid),
        .acc       (acc),
        .out_valid (rnd_valid),
        .mag       (mag),
        .neg       (neg),
        .err       (err)
    );

    hxp_pick #(.SCALE_W(SCALE_W)) u_pick
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rnd_valid),
        .mag       (mag),
        .neg       (neg),
        .err       (err),
        .out_valid (done),
        .hex_q     (hex_q),
        .hex_r     (hex_r),
        .hex_s     (hex_s)
    );

endmodule

// File: design/hxp_checker.sv
// Port-level checks of the hex tile pick, bound to the top level.
`include "pixel_to_hex_axial_pick_macros.svh"

module hxp_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  done,
    input logic signed [hxp_pkg::QR_W-1:0]       hex_q,
    input logic signed [hxp_pkg::QR_W-1:0]       hex_r,
    input logic signed [hxp_pkg::S_W-1:0]        hex_s
);

    localparam int SW = hxp_pkg::S_W;

    logic signed [SW:0] s_expect;
    logic               corner;

    // Cube identity on the clamped pair
    assign s_expect = -((SW + 1)'(hex_q) + (SW + 1)'(hex_r));
    assign corner   = (hex_q == hxp_pkg::QR_W'(hxp_pkg::QR_MIN)) &&
                      (hex_r == hxp_pkg::QR_W'(hxp_pkg::QR_MIN));

    `HXP_ASSERT_IMPL(a_latency, clk, rst_n, start && !busy, ##7 done)
    `HXP_ASSERT_IMPL(a_cube_sum, clk, rst_n, done && !corner, (SW + 1)'(hex_s) == s_expect)
    `HXP_ASSERT_IMPL(a_corner_sat, clk, rst_n, done && corner, hex_s == SW'(hxp_pkg::S_MAX))
    `HXP_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

endmodule

bind pixel_to_hex_axial_pick hxp_checker u_hxp_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .hex_q (hex_q),
    .hex_r (hex_r),
    .hex_s (hex_s)
);

// File: verif/pixel_to_hex_axial_pick_tb.sv
// Self-checking testbench for the flat-top hex tile pick: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC_BITS   = 16;
    localparam int SCALE_BITS  = FRAC_BITS + 1;
    localparam int RAND_ITEMS  = 1700;
    localparam int MAX_GAP     = 16;
    localparam int SETTLE      = hxp_pkg::PIPE_DEPTH + 3;
    localparam int TIMEOUT_NS  = 3_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int S_MIN       = -hxp_pkg::S_MAX - 1;

    // Settings used by the directed table
    typedef enum int {
        SET_RESET,
        SET_ZERO,
        SET_SAT_HIGH,
        SET_SAT_LOW,
        SET_HALF_Q,
        SET_HALF_R,
        SET_R_FROM_X
    } setting_t;

    typedef struct packed {
        logic signed [hxp_pkg::QR_W-1:0] q;
        logic signed [hxp_pkg::QR_W-1:0] r;
        logic signed [hxp_pkg::S_W-1:0]  s;
    } tile_t;

    typedef struct packed {
        logic [hxp_pkg::PIX_W-1:0] px;
        logic [hxp_pkg::PIX_W-1:0] py;
        tile_t                     tile;
    } pick_exp_t;

    typedef struct packed {
        setting_t set;
        int       px;
        int       py;
        bit       typed;
        int       eq;
        int       er;
        int       es;
    } pick_row_t;

    typedef struct {
        longint          val;
        longint unsigned err;
    } rounded_t;

    localparam int DIR_ROWS = 23;

    // Directed picks; a typed row carries its expected tile
    localparam pick_row_t PICK_TABLE [DIR_ROWS] = '{
        '{SET_RESET,     300,  195, 1'b1,     0,     0,    0},
        '{SET_RESET,       0,    0, 1'b0,     0,     0,    0},
        '{SET_RESET,    2047, 2047, 1'b0,     0,     0,    0},
        '{SET_RESET,    2047,    0, 1'b0,     0,     0,    0},
        '{SET_RESET,       0, 2047, 1'b0,     0,     0,    0},
        '{SET_RESET,     301,  195, 1'b0,     0,     0,    0},
        '{SET_ZERO,        0,    0, 1'b1,     0,     0,    0},
        '{SET_ZERO,     2047, 2047, 1'b1,     0,     0,    0},
        '{SET_ZERO,     1234,  567, 1'b1,     0,     0,    0},
        '{SET_SAT_HIGH, 2047, 2047, 1'b1,  1023,  1023, -2046},
        '{SET_SAT_HIGH,    0,    0, 1'b1,     0,     0,    0},
        '{SET_SAT_HIGH, 2047,    0, 1'b0,     0,     0,    0},
        '{SET_SAT_HIGH,    0, 2047, 1'b0,     0,     0,    0},
        '{SET_SAT_LOW,     0,    0, 1'b1, -1024, -1024, 2047},
        '{SET_SAT_LOW,  2047, 2047, 1'b1, -1024, -1024, 2047},
        '{SET_SAT_LOW,     0, 2047, 1'b0,     0,     0,    0},
        '{SET_HALF_Q,      1,    0, 1'b0,     0,     0,    0},
        '{SET_HALF_Q,      0,    0, 1'b0,     0,     0,    0},
        '{SET_HALF_Q,      2,    0, 1'b0,     0,     0,    0},
        '{SET_HALF_R,      0,    0, 1'b0,     0,     0,    0},
        '{SET_HALF_R,      0,    1, 1'b0,     0,     0,    0},
        '{SET_R_FROM_X, 2047,    0, 1'b0,     0,     0,    0},
        '{SET_R_FROM_X,    0, 2047, 1'b0,     0,     0,    0}
    };

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [hxp_pkg::PIX_W-1:0]         pixel_x;
    logic [hxp_pkg::PIX_W-1:0]         pixel_y;
    logic                              done;
    logic signed [hxp_pkg::QR_W-1:0]   hex_q;
    logic signed [hxp_pkg::QR_W-1:0]   hex_r;
    logic signed [hxp_pkg::S_W-1:0]    hex_s;
    logic                              cfg_we;
    logic [hxp_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [hxp_pkg::CFG_DATA_W-1:0]    cfg_data;

    // Typed expectation handed from the driver to the monitor
    logic                              typed_use;
    tile_t                             typed_tile;

    hxp_pkg::hxp_cfg_t                 cfg_model;
    hxp_pkg::hxp_cfg_t                 cur_setting;
    pick_exp_t                         expected_tiles [$];
    int                                fault_count;

    pixel_to_hex_axial_pick #(
        .COEF_FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .done      (done),
        .hex_q     (hex_q),
        .hex_r     (hex_r),
        .hex_s     (hex_s),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Round a value scaled by 2^SCALE_BITS half away from zero, keep the error
    function automatic rounded_t round_away(input longint a);
        longint unsigned mag;
        longint unsigned n;
        longint unsigned back;
        rounded_t        res;
        mag      = (a < 0) ? longint'(-a) : longint'(a);
        n        = (mag + (64'd1 << (SCALE_BITS - 1))) >> SCALE_BITS;
        back     = n << SCALE_BITS;
        res.err  = (back >= mag) ? back - mag : mag - back;
        res.val  = (a < 0) ? -longint'(n) : longint'(n);
        return res;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Tile under a pixel for a given register setting
    function automatic tile_t pick_tile(input hxp_pkg::hxp_cfg_t c,
                                        input logic [hxp_pkg::PIX_W-1:0] px,
                                        input logic [hxp_pkg::PIX_W-1:0] py);
        longint   dxh;
        longint   dyh;
        longint   qa;
        longint   ra;
        longint   qi;
        longint   ri;
        longint   si;
        rounded_t qr;
        rounded_t rr;
        rounded_t sr;
        tile_t    t;
        dxh = 2 * longint'(px) - longint'(c.center_x_half);
        dyh = 2 * longint'(py) - longint'(c.center_y_half);
        qa  = longint'(c.q_coef_x) * dxh;
        ra  = longint'(c.r_coef_y) * dyh - longint'(c.r_coef_x) * dxh;
        qr  = round_away(qa);
        rr  = round_away(ra);
        sr  = round_away(-qa - ra);
        qi  = qr.val;
        ri  = rr.val;
        si  = sr.val;
        // Rebuild the coordinate that strayed furthest; q only on a strict win
        if (qr.err > rr.err && qr.err > sr.err)
            qi = -ri - si;
        else if (rr.err > sr.err)
            ri = -qi - si;
        qi  = clip(qi, hxp_pkg::QR_MIN, hxp_pkg::QR_MAX);
        ri  = clip(ri, hxp_pkg::QR_MIN, hxp_pkg::QR_MAX);
        si  = clip(-qi - ri, S_MIN, hxp_pkg::S_MAX);
        t.q = qi[hxp_pkg::QR_W-1:0];
        t.r = ri[hxp_pkg::QR_W-1:0];
        t.s = si[hxp_pkg::S_W-1:0];
        return t;
    endfunction

    function automatic hxp_pkg::hxp_cfg_t directed_setting(input setting_t set);
        hxp_pkg::hxp_cfg_t c;
        c = '{hxp_pkg::RST_CENTER_X, hxp_pkg::RST_CENTER_Y, hxp_pkg::RST_Q_COEF_X,
              hxp_pkg::RST_R_COEF_X, hxp_pkg::RST_R_COEF_Y};
        case (set)
            SET_ZERO:     c = '0;
            SET_SAT_HIGH: c = '{13'd0, 13'd0, '1, 18'd0, '1};
            SET_SAT_LOW:  c = '{'1, '1, '1, 18'd0, '1};
            SET_HALF_Q:   c = '{13'd1, 13'd0, 18'd65536, 18'd0, 18'd0};
            SET_HALF_R:   c = '{13'd0, 13'd1, 18'd0, 18'd0, 18'd65536};
            SET_R_FROM_X: c = '{13'd0, 13'd4095, 18'd0, '1, 18'd0};
            default:      ;
        endcase
        return c;
    endfunction

    // Pick one coefficient or centre value: zero, full scale or anything between
    function automatic int unsigned pick_extreme(input int unsigned max_val);
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return max_val;
            default: return $urandom_range(0, max_val);
        endcase
    endfunction

    function automatic hxp_pkg::hxp_cfg_t draw_setting();
        hxp_pkg::hxp_cfg_t c;
        int                w;
        int                h;
        real               scale;
        scale = 2.0 ** FRAC_BITS;
        case ($urandom_range(0, 3))
            0:
            begin
                c.center_x_half = (hxp_pkg::CTR_W)'($urandom_range(0, 8191));
                c.center_y_half = (hxp_pkg::CTR_W)'($urandom_range(0, 8191));
                c.q_coef_x      = (hxp_pkg::COEF_W)'($urandom_range(0, 262143));
                c.r_coef_x      = (hxp_pkg::COEF_W)'($urandom_range(0, 262143));
                c.r_coef_y      = (hxp_pkg::COEF_W)'($urandom_range(0, 262143));
            end
            3:
            begin
                c.center_x_half = (hxp_pkg::CTR_W)'(pick_extreme(8191));
                c.center_y_half = (hxp_pkg::CTR_W)'(pick_extreme(8191));
                c.q_coef_x      = (hxp_pkg::COEF_W)'(pick_extreme(262143));
                c.r_coef_x      = (hxp_pkg::COEF_W)'(pick_extreme(262143));
                c.r_coef_y      = (hxp_pkg::COEF_W)'(pick_extreme(262143));
            end
            default:
            begin
                // Plausible tile sizes on a plausible screen
                w = $urandom_range(8, 400);
                h = $urandom_range(8, 400);
                c.center_x_half = (hxp_pkg::CTR_W)'($urandom_range(0, 4200));
                c.center_y_half = (hxp_pkg::CTR_W)'($urandom_range(0, 4200));
                c.q_coef_x      = (hxp_pkg::COEF_W)'($rtoi(4.0 / 3.0 / w * scale + 0.5));
                c.r_coef_x      = (hxp_pkg::COEF_W)'($rtoi(2.0 / 3.0 / w * scale + 0.5));
                c.r_coef_y      = (hxp_pkg::COEF_W)'(
                    $rtoi(2.0 * 1.7320508075688 / 3.0 / h * scale + 0.5));
            end
        endcase
        return c;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Drop start, then hold until every expected tile is back and the pipeline has emptied
    task automatic drain_tiles();
        @(negedge clk);
        start     <= 1'b0;
        typed_use <= 1'b0;
        while (expected_tiles.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic put_reg(input logic [hxp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hxp_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    // Load all five registers; junk above the centre width and a stray index on the way
    task automatic load_setting(input hxp_pkg::hxp_cfg_t c);
        logic [hxp_pkg::CFG_DATA_W-1:0] junk;
        junk = (hxp_pkg::CFG_DATA_W)'($urandom);
        put_reg((hxp_pkg::CFG_IDX_W)'(hxp_pkg::REG_R_COEF_Y + 1 + $urandom_range(0, 2)),
                (hxp_pkg::CFG_DATA_W)'($urandom));
        put_reg(hxp_pkg::REG_CENTER_X,
                {junk[hxp_pkg::CFG_DATA_W-1:hxp_pkg::CTR_W], c.center_x_half});
        junk = (hxp_pkg::CFG_DATA_W)'($urandom);
        put_reg(hxp_pkg::REG_CENTER_Y,
                {junk[hxp_pkg::CFG_DATA_W-1:hxp_pkg::CTR_W], c.center_y_half});
        put_reg(hxp_pkg::REG_Q_COEF_X, c.q_coef_x);
        put_reg(hxp_pkg::REG_R_COEF_X, c.r_coef_x);
        put_reg(hxp_pkg::REG_R_COEF_Y, c.r_coef_y);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_setting = c;
    endtask

    // Offer one pick transaction after a gap and hold it until taken
    task automatic send_pick(input logic [hxp_pkg::PIX_W-1:0] px,
                             input logic [hxp_pkg::PIX_W-1:0] py,
                             input int gap, input bit use_typed, input tile_t tt);
        if (gap > 0)
        begin
            @(negedge clk);
            start     <= 1'b0;
            pixel_x   <= (hxp_pkg::PIX_W)'($urandom);
            pixel_y   <= (hxp_pkg::PIX_W)'($urandom);
            typed_use <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        pixel_x    <= px;
        pixel_y    <= py;
        typed_use  <= use_typed;
        typed_tile <= tt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Record accepted picks, check returned tiles, track register writes
    always @(posedge clk)
    begin : tile_monitor
        pick_exp_t e;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                e.px   = pixel_x;
                e.py   = pixel_y;
                e.tile = typed_use ? typed_tile : pick_tile(cfg_model, pixel_x, pixel_y);
                expected_tiles = {expected_tiles, e};
            end
            if (done)
            begin
                if (expected_tiles.size() == 0)
                    note_fault($sformatf("unexpected tile q=%0d r=%0d s=%0d",
                                         hex_q, hex_r, hex_s));
                else
                begin
                    e = expected_tiles.pop_front();
                    if (hex_q !== e.tile.q || hex_r !== e.tile.r || hex_s !== e.tile.s)
                        note_fault($sformatf(
                            "pixel (%0d,%0d): expected q=%0d r=%0d s=%0d, got q=%0d r=%0d s=%0d",
                            e.px, e.py, e.tile.q, e.tile.r, e.tile.s, hex_q, hex_r, hex_s));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    hxp_pkg::REG_CENTER_X:
                        cfg_model.center_x_half = cfg_data[hxp_pkg::CTR_W-1:0];
                    hxp_pkg::REG_CENTER_Y:
                        cfg_model.center_y_half = cfg_data[hxp_pkg::CTR_W-1:0];
                    hxp_pkg::REG_Q_COEF_X:
                        cfg_model.q_coef_x      = cfg_data[hxp_pkg::COEF_W-1:0];
                    hxp_pkg::REG_R_COEF_X:
                        cfg_model.r_coef_x      = cfg_data[hxp_pkg::COEF_W-1:0];
                    hxp_pkg::REG_R_COEF_Y:
                        cfg_model.r_coef_y      = cfg_data[hxp_pkg::COEF_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        setting_t   cur_set;
        tile_t      tt;
        pick_row_t  row;
        int         sent;
        int         len;
        int         gap;
        bit         burst;
        logic [hxp_pkg::PIX_W-1:0] px;
        logic [hxp_pkg::PIX_W-1:0] py;

        rst_n       = 1'b0;
        start       = 1'b0;
        pixel_x     = '0;
        pixel_y     = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        typed_use   = 1'b0;
        typed_tile  = '0;
        fault_count = 0;
        cfg_model   = '{hxp_pkg::RST_CENTER_X, hxp_pkg::RST_CENTER_Y, hxp_pkg::RST_Q_COEF_X,
                        hxp_pkg::RST_R_COEF_X, hxp_pkg::RST_R_COEF_Y};
        cur_setting = cfg_model;
        cur_set     = SET_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table; change setting only once the block is idle
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = PICK_TABLE[i];
            if (row.set != cur_set)
            begin
                drain_tiles();
                load_setting(directed_setting(row.set));
                cur_set = row.set;
            end
            tt.q = row.eq[hxp_pkg::QR_W-1:0];
            tt.r = row.er[hxp_pkg::QR_W-1:0];
            tt.s = row.es[hxp_pkg::S_W-1:0];
            send_pick(row.px[hxp_pkg::PIX_W-1:0], row.py[hxp_pkg::PIX_W-1:0],
                      $urandom_range(0, 2), row.typed, tt);
        end

        // Random phases, each under a fresh register setting
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            drain_tiles();
            load_setting(draw_setting());
            burst = ($urandom_range(0, 3) == 0);
            len   = $urandom_range(60, 250);
            if (len > RAND_ITEMS - sent)
                len = RAND_ITEMS - sent;
            repeat (len)
            begin
                gap = burst ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 7) == 0)
                begin
                    // Aim near the centre, where the rounding choices bite
                    px = (hxp_pkg::PIX_W)'((cur_setting.center_x_half >> 1) +
                                           $urandom_range(0, 8) - 4);
                    py = (hxp_pkg::PIX_W)'((cur_setting.center_y_half >> 1) +
                                           $urandom_range(0, 8) - 4);
                end
                else
                begin
                    px = (hxp_pkg::PIX_W)'($urandom);
                    py = (hxp_pkg::PIX_W)'($urandom);
                end
                send_pick(px, py, gap, 1'b0, '0);
                sent++;
                // Occasionally hold off until everything is back
                if ($urandom_range(0, 99) == 0)
                    drain_tiles();
            end
        end

        @(negedge clk);
        start <= 1'b0;
        drain_tiles();
        repeat (SETTLE) @(posedge clk);

        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
